// File: hw/rtl/assert_macros.svh
// Assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// File: hw/rtl/ghpf_pkg.sv
package ghpf_pkg;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_SEEK = 1'b1
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [7:0]         cell_col;
      logic [7:0]         cell_row;
      logic signed [15:0] height_value;
   } req_type;

   typedef struct packed {
      logic [7:0]         peak_col;
      logic [7:0]         peak_row;
      logic signed [15:0] peak_height;
   } rsp_type;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLS = 1'b0,
      CSR_GRID_ROWS = 1'b1
   } csr_idx_type;

   localparam logic [CSR_DATA_W-1:0] GRID_RESET = 9'd256;

   // store read selector: which cell the step addresses
   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_HERE,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_UP,
      SEL_DOWN
   } sel_type;

   typedef enum logic [1:0] {
      CMP_NONE,
      CMP_FIRST,
      CMP_MAX
   } cmp_type;

   localparam int UPC_W = 4;

   typedef enum logic [UPC_W-1:0] {
      UP_RD_HERE,
      UP_RD_LEFT,
      UP_RD_RIGHT,
      UP_RD_UP,
      UP_RD_DOWN,
      UP_CMP_LAST,
      UP_DECIDE,
      UP_RESCAN,
      UP_FINISH
   } upc_type;

   typedef struct packed {
      sel_type rd_sel;
      logic    latch_here;
      cmp_type cmp;
      logic    decide;
      logic    done;
      upc_type next;
      upc_type alt;
   } ctrl_word_type;

   localparam ctrl_word_type CW_NOP = '{
      rd_sel: SEL_NONE, latch_here: 1'b0, cmp: CMP_NONE, decide: 1'b0,
      done: 1'b0, next: UP_RD_HERE, alt: UP_RD_HERE
   };

   // Climb program. Reads are registered, so each compare sees the read
   // issued by the step before it.
   function automatic ctrl_word_type ucode_rom(input upc_type pc);
      ctrl_word_type cw;
      cw = CW_NOP;
      unique case (pc)
         UP_RD_HERE: begin
            cw.rd_sel = SEL_HERE;
            cw.next   = UP_RD_LEFT;
         end
         UP_RD_LEFT: begin
            cw.rd_sel     = SEL_LEFT;
            cw.latch_here = 1'b1;
            cw.next       = UP_RD_RIGHT;
         end
         UP_RD_RIGHT: begin
            cw.rd_sel = SEL_RIGHT;
            cw.cmp    = CMP_FIRST;
            cw.next   = UP_RD_UP;
         end
         UP_RD_UP: begin
            cw.rd_sel = SEL_UP;
            cw.cmp    = CMP_MAX;
            cw.next   = UP_RD_DOWN;
         end
         UP_RD_DOWN: begin
            cw.rd_sel = SEL_DOWN;
            cw.cmp    = CMP_MAX;
            cw.next   = UP_CMP_LAST;
         end
         UP_CMP_LAST: begin
            cw.cmp  = CMP_MAX;
            cw.next = UP_DECIDE;
         end
         UP_DECIDE: begin
            cw.decide = 1'b1;
            cw.next   = UP_RESCAN;
            cw.alt    = UP_FINISH;
         end
         UP_RESCAN: begin
            cw.rd_sel = SEL_LEFT;
            cw.next   = UP_RD_RIGHT;
         end
         UP_FINISH: begin
            cw.done = 1'b1;
         end
         default: begin
            cw.done = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

// File: hw/rtl/ghpf_seq.sv
module ghpf_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   climb,
   input  logic                   hold,
   output ghpf_pkg::ctrl_word_type ctrl,
   output logic                   busy
);

   typedef enum logic {
      SQ_IDLE,
      SQ_RUN
   } seq_state_type;

   seq_state_type     state_ff;
   ghpf_pkg::upc_type upc_ff;
   ghpf_pkg::ctrl_word_type rom_word;

   assign rom_word = ghpf_pkg::ucode_rom(upc_ff);
   assign busy     = (state_ff == SQ_RUN);
   assign ctrl     = busy ? rom_word : ghpf_pkg::CW_NOP;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         upc_ff   <= ghpf_pkg::UP_RD_HERE;
      end else begin
         unique case (state_ff)
            SQ_IDLE: begin
               if (start) begin
                  state_ff <= SQ_RUN;
                  upc_ff   <= ghpf_pkg::UP_RD_HERE;
               end
            end
            SQ_RUN: begin
               // hold the final step while the result register is still full
               if (rom_word.done) begin
                  if (!hold) begin
                     state_ff <= SQ_IDLE;
                  end
               end else if (rom_word.decide && !climb) begin
                  upc_ff <= rom_word.alt;
               end else begin
                  upc_ff <= rom_word.next;
               end
            end
            default: begin
               state_ff <= SQ_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/ghpf_dp.sv
module ghpf_dp #(
   parameter int MAX_COLS    = 256,
   parameter int MAX_ROWS    = 256,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          load_en,
   input  logic                          start,
   input  ghpf_pkg::req_type             req,
   input  logic [ghpf_pkg::CSR_DATA_W-1:0] cols_eff,
   input  logic [ghpf_pkg::CSR_DATA_W-1:0] rows_eff,
   input  ghpf_pkg::ctrl_word_type       ctrl,
   output logic                          climb,
   output ghpf_pkg::rsp_type             peak
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = ghpf_pkg::CSR_DATA_W;
   localparam int XCW   = ((CW > DW) ? CW : DW) + 1;
   localparam int XRW   = ((RW > DW) ? RW : DW) + 1;

   logic signed [HEIGHT_BITS-1:0] store_mem [DEPTH];

   logic [CW-1:0] cur_col_ff;
   logic [RW-1:0] cur_row_ff;
   logic signed [HEIGHT_BITS-1:0] here_ff;
   logic signed [HEIGHT_BITS-1:0] best_ff;
   logic signed [HEIGHT_BITS-1:0] rd_data_ff;
   ghpf_pkg::sel_type rd_dir_ff;
   ghpf_pkg::sel_type best_dir_ff;

   logic [CW-1:0] last_col, left_col, right_col, start_col, rd_col, mv_col;
   logic [RW-1:0] last_row, up_row, down_row, start_row, rd_row, mv_row;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_inside;
   logic signed [31:0] here_wide;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c,
                                              input logic [RW-1:0] r);
      return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
   endfunction

   assign last_col = CW'(cols_eff - DW'(1));
   assign last_row = RW'(rows_eff - DW'(1));

   // neighbours, clamped to the grid in use
   assign left_col  = (cur_col_ff == '0) ? '0 : cur_col_ff - CW'(1);
   assign right_col = ((XCW'(cur_col_ff) + XCW'(1)) < XCW'(cols_eff)) ?
                      CW'(cur_col_ff + CW'(1)) : last_col;
   assign up_row    = (cur_row_ff == '0) ? '0 : cur_row_ff - RW'(1);
   assign down_row  = ((XRW'(cur_row_ff) + XRW'(1)) < XRW'(rows_eff)) ?
                      RW'(cur_row_ff + RW'(1)) : last_row;

   assign start_col = (XCW'(req.cell_col) > XCW'(last_col)) ? last_col :
                      CW'(req.cell_col);
   assign start_row = (XRW'(req.cell_row) > XRW'(last_row)) ? last_row :
                      RW'(req.cell_row);

   always_comb begin
      rd_col = cur_col_ff;
      rd_row = cur_row_ff;
      unique case (ctrl.rd_sel)
         ghpf_pkg::SEL_LEFT:  rd_col = left_col;
         ghpf_pkg::SEL_RIGHT: rd_col = right_col;
         ghpf_pkg::SEL_UP:    rd_row = up_row;
         ghpf_pkg::SEL_DOWN:  rd_row = down_row;
         default: begin
         end
      endcase
   end

   always_comb begin
      mv_col = cur_col_ff;
      mv_row = cur_row_ff;
      unique case (best_dir_ff)
         ghpf_pkg::SEL_LEFT:  mv_col = left_col;
         ghpf_pkg::SEL_RIGHT: mv_col = right_col;
         ghpf_pkg::SEL_UP:    mv_row = up_row;
         ghpf_pkg::SEL_DOWN:  mv_row = down_row;
         default: begin
         end
      endcase
   end

   assign rd_addr   = addr_of(rd_col, rd_row);
   assign wr_inside = (32'(req.cell_col) < MAX_COLS) && (32'(req.cell_row) < MAX_ROWS);
   assign wr_addr   = addr_of(CW'(req.cell_col), RW'(req.cell_row));

   always_ff @(posedge clock) begin
      if (load_en && wr_inside) begin
         store_mem[wr_addr] <= HEIGHT_BITS'(req.height_value);
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign climb = (best_ff > here_ff);

   always_ff @(posedge clock) begin
      rd_dir_ff <= ctrl.rd_sel;
      if (start) begin
         cur_col_ff <= start_col;
         cur_row_ff <= start_row;
      end else if (ctrl.decide && climb) begin
         cur_col_ff <= mv_col;
         cur_row_ff <= mv_row;
      end
      if (ctrl.latch_here) begin
         here_ff <= rd_data_ff;
      end else if (ctrl.decide && climb) begin
         here_ff <= best_ff;
      end
      unique case (ctrl.cmp)
         ghpf_pkg::CMP_FIRST: begin
            best_ff     <= rd_data_ff;
            best_dir_ff <= rd_dir_ff;
         end
         ghpf_pkg::CMP_MAX: begin
            // strict compare keeps ties on the earlier neighbour
            if (rd_data_ff > best_ff) begin
               best_ff     <= rd_data_ff;
               best_dir_ff <= rd_dir_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign here_wide         = 32'(here_ff);
   assign peak.peak_col     = 8'(cur_col_ff);
   assign peak.peak_row     = 8'(cur_row_ff);
   assign peak.peak_height  = here_wide[15:0];

endmodule

// File: hw/rtl/grid_hill_climb_peak_finder_unit.sv
// Load beat: written to the height store when accepted, one per cycle while no seek runs.
// Seek beat: result registered when the climb ends, no neighbour being higher;
// each move re-reads four neighbours through the single store read port.
// A new beat is taken once the result is registered, even while it waits on rsp_ready.
// Reset clears control and sets the grid to 256 x 256; the store is undefined until loaded.
module grid_hill_climb_peak_finder_unit #(
   parameter int MAX_COLS    = 256,
   parameter int MAX_ROWS    = 256,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ghpf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ghpf_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [ghpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ghpf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DW = ghpf_pkg::CSR_DATA_W;

   logic [DW-1:0] grid_cols_ff, grid_rows_ff;
   logic [DW-1:0] cols_eff, rows_eff;
   logic          rsp_valid_ff;
   ghpf_pkg::rsp_type rsp_data_ff;
   ghpf_pkg::rsp_type peak;
   ghpf_pkg::ctrl_word_type ctrl;
   logic busy, climb, hold, req_fire, load_en, start, finish;

   assign req_ready = !busy;
   assign req_fire  = req_valid && req_ready;
   assign load_en   = req_fire && (req_data.func == ghpf_pkg::FUNC_LOAD);
   assign start     = req_fire && (req_data.func == ghpf_pkg::FUNC_SEEK);
   assign hold      = rsp_valid_ff && !rsp_ready;
   assign finish    = ctrl.done && !hold;

   assign cols_eff = (grid_cols_ff == '0) ? DW'(1) :
                     ((32'(grid_cols_ff) > MAX_COLS) ? DW'(MAX_COLS) : grid_cols_ff);
   assign rows_eff = (grid_rows_ff == '0) ? DW'(1) :
                     ((32'(grid_rows_ff) > MAX_ROWS) ? DW'(MAX_ROWS) : grid_rows_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= ghpf_pkg::GRID_RESET;
         grid_rows_ff <= ghpf_pkg::GRID_RESET;
      end else if (csr_we) begin
         unique case (ghpf_pkg::csr_idx_type'(csr_index))
            ghpf_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            ghpf_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ghpf_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .climb (climb),
      .hold  (hold),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   ghpf_dp #(
      .MAX_COLS    (MAX_COLS),
      .MAX_ROWS    (MAX_ROWS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_dp (
      .clock    (clock),
      .load_en  (load_en),
      .start    (start),
      .req      (req_data),
      .cols_eff (cols_eff),
      .rows_eff (rows_eff),
      .ctrl     (ctrl),
      .climb    (climb),
      .peak     (peak)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish) begin
         rsp_data_ff <= peak;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/ghpf_checker.sv
`include "assert_macros.svh"

module ghpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ghpf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ghpf_pkg::rsp_type rsp_data
);

   logic seek_beat, load_beat;

   assign seek_beat = req_valid && req_ready && (req_data.func == ghpf_pkg::FUNC_SEEK);
   assign load_beat = req_valid && req_ready && (req_data.func == ghpf_pkg::FUNC_LOAD);

   // stalled result holds its beat
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // a seek blocks the input until its climb ends
   `ASSERT_NEXT(a_seek_blocks, clock, reset, seek_beat, !req_ready)
   // loads never stall the input
   `ASSERT_NEXT(a_load_free, clock, reset, load_beat, req_ready)
   // a new result appears only as a climb ends, with the input open again
   `ASSERT_IMPLIES(a_rsp_from_climb, clock, reset, $rose(rsp_valid), req_ready && $past(!req_ready))

endmodule

bind grid_hill_climb_peak_finder_unit ghpf_checker u_ghpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
